// File: design/delta_run_sample_decoder_assert.svh
// Assertion macros for the delta/run sample decoder.
`ifndef DELTA_RUN_SAMPLE_DECODER_ASSERT_SVH
`define DELTA_RUN_SAMPLE_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define DRSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define DRSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DRSD_ASSERT(lbl, prop, msg)
`define DRSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/drsd_pkg.sv
// Types, constants and helpers shared by the delta/run sample decoder.
`default_nettype none
package drsd_pkg;

  localparam logic [5:0] EXT_BASE = 6'd59;  // long fields above this take extension bytes
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [30:0]        repeat_count;
    logic               last_of_byte;
    logic               frame_done;
    logic               status;
  } res_t;

  typedef struct packed {
    logic [31:0] ref_value;
    logic [30:0] samples_left;
    logic        pend_run;     // pending long tag is a run
    logic [2:0]  ext_total;    // 0: no tag pending
    logic [1:0]  ext_idx;
    logic [31:0] long_field;
    logic        err_seen;
  } state_t;

  typedef struct packed {
    state_t                  nxt;
    res_t [MAX_RES-1:0]      res;
    logic [1:0]              n_res;
  } step_t;

  localparam res_t OVERRUN_RES = '{sample_value: '0, repeat_count: '0,
                                   last_of_byte: 1'b1, frame_done: 1'b0,
                                   status: 1'b1};

  function automatic logic [31:0] unzig(input logic [31:0] v);
    return v[0] ? ~(v >> 1) : (v >> 1);
  endfunction

  function automatic res_t mk_res(input logic [31:0] val, input logic [30:0] rep,
                                  input logic [30:0] left, input logic last);
    res_t r;
    r.sample_value = val;
    r.repeat_count = rep;
    r.last_of_byte = last;
    r.frame_done   = (left == '0);
    r.status       = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/drsd_if.sv
// Valid/ready channel interfaces: compressed byte in, decoded word out.
`default_nettype none
interface drsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface drsd_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic [30:0]        repeat_count;
  logic               last_of_byte;
  logic               frame_done;
  logic               status;
  modport source (output valid, output sample_value, output repeat_count,
                  output last_of_byte, output frame_done, output status,
                  input ready);
  modport sink   (input valid, input sample_value, input repeat_count,
                  input last_of_byte, input frame_done, input status,
                  output ready);
endinterface
`default_nettype wire

// File: design/drsd_step.sv
// Per-byte decode: next state and up to three result words from one byte.
`default_nettype none
module drsd_step (
  input  drsd_pkg::state_t st_i,
  input  logic [7:0]       byte_i,
  output drsd_pkg::step_t  step_o
);
  import drsd_pkg::*;

  always_comb begin : p_step
    logic [31:0] lf;
    logic [31:0] nf;
    logic        run;
    logic        do_long;
    logic [31:0] same;
    logic [32:0] need;
    logic [31:0] d0, d1, d2;
    logic [31:0] acc;
    logic [30:0] sl1, sl2, sl3;
    logic [5:0]  n6;

    step_o     = '0;
    step_o.nxt = st_i;
    lf      = st_i.long_field + ((32'(byte_i) + 32'd1) << {st_i.ext_idx, 3'b000});
    nf      = '0;
    run     = 1'b0;
    do_long = 1'b0;
    n6      = byte_i[5:0];
    d0      = '0;
    d1      = '0;
    d2      = '0;
    acc     = '0;
    sl1     = st_i.samples_left - 31'd1;
    sl2     = st_i.samples_left - 31'd2;
    sl3     = st_i.samples_left - 31'd3;

    if (st_i.err_seen) begin
      // sticky: everything dropped until the count is rewritten
    end else if (st_i.ext_total != '0) begin
      step_o.nxt.long_field = lf;
      if (({1'b0, st_i.ext_idx} + 3'd1) < st_i.ext_total) begin
        step_o.nxt.ext_idx = st_i.ext_idx + 2'd1;
      end else begin
        step_o.nxt.ext_total = '0;
        step_o.nxt.ext_idx   = '0;
        do_long = 1'b1;
        nf      = lf;
        run     = st_i.pend_run;
      end
    end else if (st_i.samples_left == '0) begin
      // frame finished
    end else if (byte_i[7]) begin
      if (n6 > EXT_BASE) begin
        step_o.nxt.pend_run   = byte_i[6];
        step_o.nxt.ext_total  = 3'(n6 - EXT_BASE);
        step_o.nxt.ext_idx    = '0;
        step_o.nxt.long_field = 32'(EXT_BASE);
      end else begin
        do_long = 1'b1;
        nf      = 32'(n6);
        run     = byte_i[6];
      end
    end else if (byte_i[6]) begin
      if (st_i.samples_left < 31'd2) begin
        step_o.res[0]       = OVERRUN_RES;
        step_o.n_res        = 2'd1;
        step_o.nxt.err_seen = 1'b1;
      end else begin
        d0  = unzig(32'(byte_i[2:0]));
        d1  = unzig(32'(byte_i[5:3]));
        acc = st_i.ref_value + d1;
        step_o.res[0] = mk_res(st_i.ref_value + d0, 31'd1, sl1, 1'b0);
        step_o.res[1] = mk_res(acc, 31'd1, sl2, 1'b1);
        step_o.n_res  = 2'd2;
        step_o.nxt.ref_value    = acc;
        step_o.nxt.samples_left = sl2;
      end
    end else begin
      if (st_i.samples_left < 31'd3) begin
        step_o.res[0]       = OVERRUN_RES;
        step_o.n_res        = 2'd1;
        step_o.nxt.err_seen = 1'b1;
      end else begin
        d0  = unzig(32'(byte_i[1:0]));
        d1  = unzig(32'(byte_i[3:2]));
        d2  = unzig(32'(byte_i[5:4]));
        acc = st_i.ref_value + d2;
        step_o.res[0] = mk_res(st_i.ref_value + d0, 31'd1, sl1, 1'b0);
        step_o.res[1] = mk_res(st_i.ref_value + d1, 31'd1, sl2, 1'b0);
        step_o.res[2] = mk_res(acc, 31'd1, sl3, 1'b1);
        step_o.n_res  = 2'd3;
        step_o.nxt.ref_value    = acc;
        step_o.nxt.samples_left = sl3;
      end
    end

    // long delta or run, from the tag itself or after its last extension
    same = {1'b0, nf[31:1]} + 32'd3;
    need = {1'b0, same} + 33'd1;
    if (do_long) begin
      if (run) begin
        if (need > {2'b00, st_i.samples_left}) begin
          step_o.res[0]       = OVERRUN_RES;
          step_o.n_res        = 2'd1;
          step_o.nxt.err_seen = 1'b1;
        end else begin
          sl2 = sl1 - same[30:0];
          step_o.res[0] = mk_res(st_i.ref_value + {31'd0, nf[0]}, 31'd1, sl1, 1'b0);
          step_o.res[1] = mk_res(st_i.ref_value, same[30:0], sl2, 1'b1);
          step_o.n_res  = 2'd2;
          step_o.nxt.samples_left = sl2;
        end
      end else begin
        if (st_i.samples_left == '0) begin
          step_o.res[0]       = OVERRUN_RES;
          step_o.n_res        = 2'd1;
          step_o.nxt.err_seen = 1'b1;
        end else begin
          acc = st_i.ref_value + unzig(nf);
          step_o.res[0] = mk_res(acc, 31'd1, sl1, 1'b1);
          step_o.n_res  = 2'd1;
          step_o.nxt.ref_value    = acc;
          step_o.nxt.samples_left = sl1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/delta_run_sample_decoder.sv
// Delta/run sample decoder: top level with byte register, state and result buffer.
//
// byte_i carries one compressed byte per word; res_o carries decoded sample words
// (value, repeat count, last-of-byte, frame-done, overrun status). Both channels
// move a word at a rising edge with valid and ready high.
// cfg_we_i/cfg_wdata_i load the sample count and restart decoding from reference
// zero; write it only when the block is idle.
// Flow: a byte accepted into the byte register is decoded from there into the
// result buffer, whose first word drives res_o.
// Throughput: one byte per cycle for bytes with zero or one result while the
// receiver takes each word; after a byte with two or three results, a next byte
// with results waits until the last buffered word is taken, one word per cycle
// while ready is high. The byte register takes a byte only when empty or firing.
// Reset clears the decode state to a zero sample count, so bytes are dropped until
// the count is written. If the receiver stalls, the buffer holds its words and
// the next byte waits in the byte register; byte_i.ready then falls.
`default_nettype none
`include "delta_run_sample_decoder_assert.svh"
module delta_run_sample_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  drsd_byte_if.sink         byte_i,
  drsd_res_if.source        res_o
);
  import drsd_pkg::*;

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  state_t               st_q;
  state_t               st_d;
  res_t [MAX_RES-1:0]   buf_q;
  logic [1:0]           cnt_q;
  step_t                step;
  logic                 pop;
  logic                 fire;

  drsd_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .step_o (step)
  );

  assign pop  = res_o.valid && res_o.ready;
  // decode when the buffer is free by the next edge, or the byte makes no word
  assign fire = in_vld_q && (step.n_res == 2'd0 || cnt_q == 2'd0 ||
                             (cnt_q == 2'd1 && pop));

  assign byte_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  always_comb begin
    st_d = st_q;
    if (cfg_we_i) begin
      st_d              = '0;
      st_d.samples_left = cfg_wdata_i;
    end else if (fire) begin
      st_d = step.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire && step.n_res != 2'd0) begin
      cnt_q <= step.n_res;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step.n_res != 2'd0) begin
      buf_q <= step.res;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign res_o.valid        = (cnt_q != 2'd0);
  assign res_o.sample_value = buf_q[0].sample_value;
  assign res_o.repeat_count = buf_q[0].repeat_count;
  assign res_o.last_of_byte = buf_q[0].last_of_byte;
  assign res_o.frame_done   = buf_q[0].frame_done;
  assign res_o.status       = buf_q[0].status;

  `DRSD_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |=> !res_o.valid, "word during reset")
  `DRSD_ASSERT(a_err_sticky, st_q.err_seen && !cfg_we_i |=> st_q.err_seen, "error cleared")
  `DRSD_ASSERT(a_overrun_word, res_o.valid && res_o.status |->
    (res_o.last_of_byte && res_o.repeat_count == '0 && !res_o.frame_done), "bad overrun word")
  `DRSD_ASSERT(a_load_shows, fire && step.n_res != 2'd0 |=> res_o.valid, "decoded words lost")

endmodule
`default_nettype wire
